/* sv/dtq_pkg.sv */
`default_nettype none

package dtq_pkg;

    localparam int TIMER_SLOTS_DEF   = 32;
    localparam int QUEUE_DEPTH_DEF   = 32;
    localparam int CALLBACK_BITS_DEF = 16;

    localparam int TIME_W    = 64;
    localparam int CB_PORT_W = 16;
    localparam int COUNT_W   = 7;
    localparam int MAX_FIRE  = 64;

    localparam int S_TDATA_W = 152;
    localparam int M_TDATA_W = 24;

    typedef logic [1:0] t_op;
    localparam t_op OP_ARM   = 2'd0;
    localparam t_op OP_QUEUE = 2'd1;
    localparam t_op OP_TICK  = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_BADARG = 2'd1;
    localparam t_status ST_FULL   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ARM,
        S_POP,
        S_SCAN,
        S_FIN
    } t_state;

    typedef struct packed {
        t_status              status;
        logic                 fired_valid;
        logic [CB_PORT_W-1:0] callback_out;
        logic                 last;
        logic [COUNT_W-1:0]   fired_count;
    } t_result;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_ctl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_sts;

    function automatic t_result mk_result(input t_status status, input logic fired_valid,
                                          input logic [CB_PORT_W-1:0] callback_out,
                                          input logic last,
                                          input logic [COUNT_W-1:0] fired_count);
        t_result r;
        r.status       = status;
        r.fired_valid  = fired_valid;
        r.callback_out = callback_out;
        r.last         = last;
        r.fired_count  = fired_count;
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/dtq_fifo.sv */
`default_nettype none

module dtq_fifo
    import dtq_pkg::*;
#(
    parameter int DEPTH  = QUEUE_DEPTH_DEF,
    parameter int DATA_W = CALLBACK_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_fifo_ctl         i_ctl,
    input  wire logic [DATA_W-1:0] i_push_data,
    output t_fifo_sts              o_sts,
    output logic [DATA_W-1:0]      o_head_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_count, n_count;
    logic [CW:0]       tail_sum;
    logic [CW:0]       tail_wrap;
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd;

    // Tail is head plus count, folded back once since the sum stays below twice the depth.
    assign tail_sum  = (CW+1)'(r_head) + (CW+1)'(r_count);
    assign tail_wrap = (tail_sum >= (CW+1)'(DEPTH)) ? tail_sum - (CW+1)'(DEPTH) : tail_sum;

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_ctl.pop) begin
            n_head  = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
            n_count = r_count - CW'(1);
        end else if (i_ctl.push) begin
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Reads follow the next head; data matches r_head but lags a write to the head slot.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[tail_wrap[AW-1:0]] <= i_push_data;
        end
        r_rd <= r_mem[n_head];
    end

    assign o_sts.empty = (r_count == '0);
    assign o_sts.full  = (r_count == CW'(DEPTH));
    assign o_head_data = r_rd;

endmodule

`default_nettype wire

/* sv/deadline_timer_and_deferred_queue.sv */
// Deadline timer table with a deferred-callback queue. Op 0 (arm) stores
// deadline now+delay (wrapping at 64 bits) in the lowest free timer slot and
// answers ok or full; it walks the slot-used bits one slot per cycle. Op 1
// (queue) pushes a callback id and answers ok or full from the idle state.
// Op 2 (tick) first pops queued ids, then visits the timer slots in index
// order and fires and frees every used slot whose deadline is not after now,
// stopping after max_count results (saturated at 64; zero is a bad argument).
// Slots are read one per cycle, unless a fired slot waits on a stalled output,
// through the single read port of the timer memories. Results leave through
// an output register, one transfer per cycle at most; a stalled output holds
// the sequencer until the result is taken.
`default_nettype none

module deadline_timer_and_deferred_queue
    import dtq_pkg::*;
#(
    parameter int TIMER_SLOTS   = TIMER_SLOTS_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
    parameter int CALLBACK_BITS = CALLBACK_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // delay[63:0], callback_id[79:64], now[143:80], max_count[150:144], zero pad
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // op[1:0]
    input  wire logic [1:0]           s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // callback_out[15:0], fired_count[22:16], zero pad
    output logic [M_TDATA_W-1:0]      m_axis_tdata,
    // status[1:0], fired_valid[2]
    output logic [2:0]                m_axis_tuser,
    output logic                      m_axis_tlast
);

    localparam int IW   = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CB_W = (CALLBACK_BITS < CB_PORT_W) ? CALLBACK_BITS : CB_PORT_W;

    t_state                 r_state, n_state;
    logic [IW-1:0]          r_idx, n_idx;
    logic [TIMER_SLOTS-1:0] r_used, n_used;
    logic [TIME_W-1:0]      r_time, n_time;
    logic [CB_W-1:0]        r_cb, n_cb;
    logic [COUNT_W-1:0]     r_limit, n_limit;
    logic [COUNT_W-1:0]     r_n, n_n;
    t_result                r_pend, n_pend;
    logic                   r_pvalid, n_pvalid;
    t_result                r_out, n_out;
    logic                   r_ovalid, n_ovalid;

    logic [TIME_W-1:0]      r_dl_mem [TIMER_SLOTS];
    logic [CB_W-1:0]        r_cb_mem [TIMER_SLOTS];
    logic [TIME_W-1:0]      r_rd_dl;
    logic [CB_W-1:0]        r_rd_cb;
    logic                   arm_we;

    t_op                    in_op;
    logic [TIME_W-1:0]      in_delay;
    logic [CB_PORT_W-1:0]   in_cb;
    logic [TIME_W-1:0]      in_now;
    logic [COUNT_W-1:0]     in_max;

    t_fifo_ctl              fifo_ctl;
    t_fifo_sts              fifo_sts;
    logic [CB_W-1:0]        fifo_head;

    logic in_acc, out_free, can_emit, done_fire, at_end, fire;

    assign in_op    = s_axis_tuser;
    assign in_delay = s_axis_tdata[63:0];
    assign in_cb    = s_axis_tdata[79:64];
    assign in_now   = s_axis_tdata[143:80];
    assign in_max   = s_axis_tdata[150:144];

    assign out_free      = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign can_emit      = !r_pvalid || out_free;
    assign done_fire     = (r_n == r_limit);
    assign at_end        = (r_idx == IW'(TIMER_SLOTS - 1));
    assign fire          = r_used[r_idx] && (r_rd_dl <= r_time);

    dtq_fifo #(
        .DEPTH  (QUEUE_DEPTH),
        .DATA_W (CB_W)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (fifo_ctl),
        .i_push_data (in_cb[CB_W-1:0]),
        .o_sts       (fifo_sts),
        .o_head_data (fifo_head)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (in_op == OP_ARM) begin
                        n_state = S_ARM;
                    end else if (in_op == OP_TICK && in_max != '0) begin
                        n_state = S_POP;
                    end
                end
            end
            S_ARM: begin
                if ((!r_used[r_idx] || at_end) && out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_POP: begin
                if (fifo_sts.empty || done_fire) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (done_fire) begin
                    n_state = S_FIN;
                end else if (at_end && (!fire || can_emit)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_idx        = r_idx;
        n_used       = r_used;
        n_time       = r_time;
        n_cb         = r_cb;
        n_limit      = r_limit;
        n_n          = r_n;
        n_pend       = r_pend;
        n_pvalid     = r_pvalid;
        n_out        = r_out;
        n_ovalid     = r_ovalid && !m_axis_tready;
        arm_we       = 1'b0;
        fifo_ctl     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (in_op)
                        OP_ARM: begin
                            n_time = in_delay + in_now;
                            n_cb   = in_cb[CB_W-1:0];
                            n_idx  = '0;
                        end
                        OP_QUEUE: begin
                            n_ovalid = 1'b1;
                            if (fifo_sts.full) begin
                                n_out = mk_result(ST_FULL, 1'b0, '0, 1'b1, '0);
                            end else begin
                                fifo_ctl.push = 1'b1;
                                n_out = mk_result(ST_OK, 1'b0, '0, 1'b1, '0);
                            end
                        end
                        OP_TICK: begin
                            if (in_max == '0) begin
                                n_ovalid = 1'b1;
                                n_out    = mk_result(ST_BADARG, 1'b0, '0, 1'b1, '0);
                            end else begin
                                n_time   = in_now;
                                n_limit  = (in_max > COUNT_W'(MAX_FIRE)) ?
                                           COUNT_W'(MAX_FIRE) : in_max;
                                n_n      = '0;
                                n_idx    = '0;
                                n_pvalid = 1'b0;
                            end
                        end
                        default: begin
                            n_ovalid = 1'b1;
                            n_out    = mk_result(ST_BADARG, 1'b0, '0, 1'b1, '0);
                        end
                    endcase
                end
            end
            S_ARM: begin
                if (!r_used[r_idx]) begin
                    if (out_free) begin
                        arm_we        = 1'b1;
                        n_used[r_idx] = 1'b1;
                        n_ovalid      = 1'b1;
                        n_out         = mk_result(ST_OK, 1'b0, '0, 1'b1, '0);
                    end
                end else if (at_end) begin
                    if (out_free) begin
                        n_ovalid = 1'b1;
                        n_out    = mk_result(ST_FULL, 1'b0, '0, 1'b1, '0);
                    end
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_POP: begin
                // Each fired id waits in the pending stage until the next one
                // shows that it is not the last of the tick.
                if (!fifo_sts.empty && !done_fire && can_emit) begin
                    fifo_ctl.pop = 1'b1;
                    if (r_pvalid) begin
                        n_ovalid = 1'b1;
                        n_out    = r_pend;
                    end
                    n_pend   = mk_result(ST_OK, 1'b1, CB_PORT_W'(fifo_head), 1'b0,
                                         r_n + COUNT_W'(1));
                    n_pvalid = 1'b1;
                    n_n      = r_n + COUNT_W'(1);
                end
            end
            S_SCAN: begin
                if (!done_fire) begin
                    if (fire) begin
                        if (can_emit) begin
                            n_used[r_idx] = 1'b0;
                            if (r_pvalid) begin
                                n_ovalid = 1'b1;
                                n_out    = r_pend;
                            end
                            n_pend   = mk_result(ST_OK, 1'b1, CB_PORT_W'(r_rd_cb), 1'b0,
                                                 r_n + COUNT_W'(1));
                            n_pvalid = 1'b1;
                            n_n      = r_n + COUNT_W'(1);
                            if (!at_end) begin
                                n_idx = r_idx + IW'(1);
                            end
                        end
                    end else if (!at_end) begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    if (r_pvalid) begin
                        n_out      = r_pend;
                        n_out.last = 1'b1;
                        n_pvalid   = 1'b0;
                    end else begin
                        n_out = mk_result(ST_OK, 1'b0, '0, 1'b1, '0);
                    end
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_pvalid <= 1'b0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_pvalid <= n_pvalid;
            r_ovalid <= n_ovalid;
            r_idx    <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_time  <= n_time;
        r_cb    <= n_cb;
        r_limit <= n_limit;
        r_n     <= n_n;
        r_pend  <= n_pend;
        r_out   <= n_out;
    end

    // Timer memories are read at the next slot index, so the registered data
    // belongs to r_idx; arm writes never overlap a scan.
    always_ff @(posedge i_clk) begin
        if (arm_we) begin
            r_dl_mem[r_idx] <= r_time;
            r_cb_mem[r_idx] <= r_cb;
        end
        r_rd_dl <= r_dl_mem[n_idx];
        r_rd_cb <= r_cb_mem[n_idx];
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_out.fired_count, r_out.callback_out};
    assign m_axis_tuser  = {r_out.fired_valid, r_out.status};
    assign m_axis_tlast  = r_out.last;

endmodule

`default_nettype wire
